[hw/rtl/dtrp_pkg.sv]
// ----------------------------------------------------------------------------
// dtrp_pkg: shared types and constants of the throttle ramp block
// Percent and pulse widths, ramp curve table and the command passed from the
// front end through the queue to the step engine.
// ----------------------------------------------------------------------------
package dtrp_pkg;

    localparam int PctW   = 7;
    localparam int PulseW = 11;
    localparam int CurveW = 17;

    // Ramp length range and default
    localparam int RampStepsMin     = 2;
    localparam int RampStepsMax     = 8;
    localparam int RampStepsDefault = 5;

    localparam logic [PctW-1:0] PctMax      = 7'd100;
    localparam logic [PctW-1:0] ThreshReset = 7'd10;

    localparam logic [PulseW-1:0] PulseOff    = 11'd1000;
    localparam logic [PulseW-1:0] PulseMinRun = 11'd1100;

    // 900/99 in Q16, rounded so that floor(x * PulseScale / 2^16) equals
    // floor(x * 900 / 99) for every x in 0..99
    localparam int                ScaleW     = 20;
    localparam logic [ScaleW-1:0] PulseScale = 20'd595800;

    // Command queue depth
    localparam int QueueDepth = 2;

    // (i/n)^1.8 in Q1.16, row n, column i-1
    localparam logic [CurveW-1:0] CurveQ16 [9][8] = '{
        '{17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0},
        '{17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0},
        '{17'd18820, 17'd65536, 17'd0,     17'd0,     17'd0,     17'd0,     17'd0,     17'd0},
        '{17'd9071,  17'd31588, 17'd65536, 17'd0,     17'd0,     17'd0,     17'd0,     17'd0},
        '{17'd5405,  17'd18820, 17'd39047, 17'd65536, 17'd0,     17'd0,     17'd0,     17'd0},
        '{17'd3617,  17'd12595, 17'd26131, 17'd43857, 17'd65536, 17'd0,     17'd0,     17'd0},
        '{17'd2605,  17'd9071,  17'd18820, 17'd31588, 17'd47201, 17'd65536, 17'd0,     17'd0},
        '{17'd1974,  17'd6873,  17'd14260, 17'd23934, 17'd35764, 17'd49656, 17'd65536, 17'd0},
        '{17'd1552,  17'd5405,  17'd11213, 17'd18820, 17'd28123, 17'd39047, 17'd51534, 17'd65536}
    };

    // One command: a single step (base = target, delta = 0) or a ramp
    typedef struct packed {
        logic            ramp;
        logic [PctW-1:0] base_l;
        logic [PctW-1:0] base_r;
        logic [PctW-1:0] delta_l;
        logic [PctW-1:0] delta_r;
    } t_cmd;

endpackage

[hw/rtl/dtrp_front.sv]
// ----------------------------------------------------------------------------
// dtrp_front: target intake and classification
// Clamps targets, compares them with the current throttle, decides between a
// single step and a ramp, and pushes the resulting command to the queue.
// ----------------------------------------------------------------------------
module dtrp_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dtrp_pkg::PctW-1:0]   i_left_target,
    input  logic [dtrp_pkg::PctW-1:0]   i_right_target,
    input  logic                        i_cfg_wr_en,
    input  logic [dtrp_pkg::PctW-1:0]   i_cfg_wr_data,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output dtrp_pkg::t_cmd              o_cmd
);
    import dtrp_pkg::*;

    logic [PctW-1:0] r_thresh;
    logic [PctW-1:0] r_cur_l;
    logic [PctW-1:0] r_cur_r;

    logic [PctW-1:0] tgt_l;
    logic [PctW-1:0] tgt_r;
    logic [PctW-1:0] delta_l;
    logic [PctW-1:0] delta_r;
    logic            drop;
    logic            small_rise;
    logic            ramp;

    // Clamp targets and classify the move
    always_comb begin
        tgt_l      = (i_left_target  > PctMax) ? PctMax : i_left_target;
        tgt_r      = (i_right_target > PctMax) ? PctMax : i_right_target;
        drop       = (tgt_l < r_cur_l) || (tgt_r < r_cur_r);
        delta_l    = tgt_l - r_cur_l;
        delta_r    = tgt_r - r_cur_r;
        small_rise = (delta_l < r_thresh) && (delta_r < r_thresh);
        ramp       = !drop && !small_rise;
    end

    // Build the command
    always_comb begin
        o_cmd.ramp    = ramp;
        o_cmd.base_l  = ramp ? r_cur_l : tgt_l;
        o_cmd.base_r  = ramp ? r_cur_r : tgt_r;
        o_cmd.delta_l = ramp ? delta_l : '0;
        o_cmd.delta_r = ramp ? delta_r : '0;
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Hold threshold and current throttle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= ThreshReset;
            r_cur_l  <= '0;
            r_cur_r  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (o_push) begin
                r_cur_l <= tgt_l;
                r_cur_r <= tgt_r;
            end
        end
    end

endmodule

[hw/rtl/dtrp_queue.sv]
// ----------------------------------------------------------------------------
// dtrp_queue: command queue
// Short first-in first-out buffer between the front end and the step engine.
// ----------------------------------------------------------------------------
module dtrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dtrp_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_head_valid,
    output dtrp_pkg::t_cmd  o_head,
    input  logic            i_pop
);
    import dtrp_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

    t_cmd            r_mem [QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full       = (r_count == CntW'(QueueDepth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/dtrp_back.sv]
// ----------------------------------------------------------------------------
// dtrp_back: ramp step engine
// Issues one step per cycle from the queue head unless stalled, scales the
// delta by the curve factor, adds the base, converts percent to pulse width.
// ----------------------------------------------------------------------------
module dtrp_back #(
    parameter int RAMP_STEPS = dtrp_pkg::RampStepsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  dtrp_pkg::t_cmd                i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dtrp_pkg::PulseW-1:0]   o_left_pulse,
    output logic [dtrp_pkg::PulseW-1:0]   o_right_pulse,
    output logic                          o_last_step
);
    import dtrp_pkg::*;

    localparam int NSteps = (RAMP_STEPS < RampStepsMin) ? RampStepsMin :
                            (RAMP_STEPS > RampStepsMax) ? RampStepsMax : RAMP_STEPS;
    localparam int StepW  = $clog2(NSteps);
    localparam logic [StepW-1:0] StepLast = StepW'(NSteps - 1);
    localparam int ProdW  = PctW + CurveW;
    localparam int PulseProdW = PctW + ScaleW;

    logic [StepW-1:0] r_step;

    // Stage 1: scaled increments
    logic            r1_valid;
    logic            r1_last;
    logic [PctW-1:0] r1_base_l;
    logic [PctW-1:0] r1_base_r;
    logic [PctW-1:0] r1_inc_l;
    logic [PctW-1:0] r1_inc_r;

    // Stage 2: percent per channel
    logic            r2_valid;
    logic            r2_last;
    logic [PctW-1:0] r2_pct_l;
    logic [PctW-1:0] r2_pct_r;

    // Stage 3: output register
    logic              r_out_valid;
    logic              r_out_last;
    logic [PulseW-1:0] r_out_l;
    logic [PulseW-1:0] r_out_r;

    logic              advance;
    logic              issue;
    logic              step_last;
    logic [CurveW-1:0] factor;
    logic [ProdW-1:0]  prod_l;
    logic [ProdW-1:0]  prod_r;
    logic [PctW:0]     sum_l;
    logic [PctW:0]     sum_r;
    logic [PulseW-1:0] pulse_l;
    logic [PulseW-1:0] pulse_r;

    // Percent to pulse: 0 is off, otherwise 1100 + (p-1)*900/99
    function automatic logic [PulseW-1:0] pct_to_pulse(input logic [PctW-1:0] p);
        logic [PulseProdW-1:0] scaled;
        scaled = PulseProdW'(p - 1'b1) * PulseProdW'(PulseScale);
        if (p == '0) begin
            return PulseOff;
        end
        return PulseMinRun + scaled[PulseProdW-1:16];
    endfunction

    // Move the whole pipeline when the output register is free
    assign advance   = !r_out_valid || !i_stall;
    assign issue     = advance && i_head_valid;
    assign step_last = !i_head.ramp || (r_step == StepLast);
    assign o_pop     = issue && step_last;
    assign factor    = CurveQ16[NSteps][3'(r_step)];

    assign prod_l  = ProdW'(i_head.delta_l) * ProdW'(factor);
    assign prod_r  = ProdW'(i_head.delta_r) * ProdW'(factor);
    assign sum_l   = {1'b0, r1_base_l} + {1'b0, r1_inc_l};
    assign sum_r   = {1'b0, r1_base_r} + {1'b0, r1_inc_r};
    assign pulse_l = pct_to_pulse(r2_pct_l);
    assign pulse_r = pct_to_pulse(r2_pct_r);

    // Control: step counter and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            if (issue) begin
                r_step <= step_last ? '0 : r_step + 1'b1;
            end
            r1_valid    <= issue;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_last    <= step_last;
            r1_base_l  <= i_head.base_l;
            r1_base_r  <= i_head.base_r;
            r1_inc_l   <= prod_l[16 +: PctW];
            r1_inc_r   <= prod_r[16 +: PctW];
            r2_last    <= r1_last;
            r2_pct_l   <= sum_l[PctW-1:0];
            r2_pct_r   <= sum_r[PctW-1:0];
            r_out_last <= r2_last;
            r_out_l    <= pulse_l;
            r_out_r    <= pulse_r;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_last_step   = r_out_last;
    assign o_left_pulse  = r_out_l;
    assign o_right_pulse = r_out_r;

endmodule

[hw/rtl/dual_throttle_ramp_pulse_top.sv]
// ----------------------------------------------------------------------------
// dual_throttle_ramp_pulse_top: two-channel throttle ramp to ESC pulses
// Turns left/right throttle targets in percent into ESC pulse-width pairs,
// ramping large rises along a 1.8-power curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a target pair. Each
//   transaction yields one pulse pair, or RAMP_STEPS pairs when neither
//   channel drops and the rise on either reaches the fast threshold;
//   o_last_step marks the final pair of a transaction.
//   Output channel (o_out_valid / i_out_stall) carries the pulse pairs.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data to the fast threshold;
//   write it only while no transaction is in flight.
//   Path: once an input transaction is accepted, its first pulse pair passes
//   the queue, scale, sum and pulse output stages in turn.
//   Throughput: the step engine issues one pulse pair per cycle unless
//   stalled: one step per single move, RAMP_STEPS (5 by default) per ramp.
//   A 2-entry command queue lets new targets be accepted during a ramp.
//   Reset (i_rst_n low, synchronous) clears the current throttle to 0, the
//   threshold to 10 and empties the queue and pipeline.
//   When i_out_stall is high with a pair presented, that pair holds and the
//   engine freezes; once the queue fills, o_in_stall rises.
// ----------------------------------------------------------------------------
module dual_throttle_ramp_pulse_top #(
    parameter int RAMP_STEPS = dtrp_pkg::RampStepsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dtrp_pkg::PctW-1:0]     i_left_target,
    input  logic [dtrp_pkg::PctW-1:0]     i_right_target,
    input  logic                          i_cfg_wr_en,
    input  logic [dtrp_pkg::PctW-1:0]     i_cfg_wr_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dtrp_pkg::PulseW-1:0]   o_left_pulse,
    output logic [dtrp_pkg::PulseW-1:0]   o_right_pulse,
    output logic                          o_last_step
);
    import dtrp_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic head_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Classify incoming targets
    dtrp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_left_target  (i_left_target),
        .i_right_target (i_right_target),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_queue_full   (queue_full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Buffer commands
    dtrp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head_cmd),
        .i_pop        (pop)
    );

    // Generate pulse pairs
    dtrp_back #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_left_pulse  (o_left_pulse),
        .o_right_pulse (o_right_pulse),
        .o_last_step   (o_last_step)
    );

endmodule

[hw/rtl/dtrp_checker.sv]
// ----------------------------------------------------------------------------
// dtrp_checker: port-level checks of the throttle ramp block
// Watches the top-level output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module dtrp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [dtrp_pkg::PulseW-1:0]   o_left_pulse,
    input logic [dtrp_pkg::PulseW-1:0]   o_right_pulse,
    input logic                          o_last_step
);
    import dtrp_pkg::*;

    // Stalled transaction holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_left_pulse) && $stable(o_right_pulse)
             && $stable(o_last_step)))
        else $error("output payload changed under stall");

    // Pulse widths stay in the ESC range
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_left_pulse >= PulseOff && o_left_pulse <= 11'd2000 &&
             o_right_pulse >= PulseOff && o_right_pulse <= 11'd2000))
        else $error("pulse width out of range");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Ramp steps leave back to back
    a_ramp_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_step) |=> o_out_valid)
        else $error("gap inside a ramp");

endmodule

bind dual_throttle_ramp_pulse_top dtrp_checker u_dtrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_left_pulse  (o_left_pulse),
    .o_right_pulse (o_right_pulse),
    .o_last_step   (o_last_step)
);
